FILE: rtl/core/drld_pkg.sv
// drld_pkg: shared types and constants for the data-run list decoder
// no dependencies; imported by drld_parser, drld_records and data_run_list_decoder

package drld_pkg;

    localparam int BYTE_W     = 8;
    localparam int VALUE_W    = 64;
    localparam int BPC_W      = 22;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 4;
    localparam int HALF_W     = VALUE_W / 2;

    // record size must stay a power of two (256 to 4096)
    localparam int RECORD_SIZE = 1024;
    localparam int REC_SHIFT   = $clog2(RECORD_SIZE);

    localparam logic [BPC_W-1:0] BPC_RESET = BPC_W'(4096);
    localparam logic [COUNT_W-1:0] MAX_FIELD_BYTES = COUNT_W'(8);

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN       = 2'd0,
        ST_END       = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_MALFORMED = 2'd3
    } drld_status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_LENGTH = 3'b010,
        PH_OFFSET = 3'b100
    } drld_phase_t;

    typedef struct packed {
        drld_status_t        status;
        logic [VALUE_W-1:0]  clusters;
        logic [VALUE_W-1:0]  start;
    } drld_run_t;

endpackage

FILE: rtl/core/drld_parser.sv
// drld_parser: byte-wise run list state machine, running start cluster and result register
// depends on drld_pkg

module drld_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [drld_pkg::BYTE_W-1:0] in_byte,
    input  logic                        in_start,
    input  logic                        in_at_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output drld_pkg::drld_run_t         out_run
);
    import drld_pkg::*;

    drld_phase_t          phase_reg, phase_next;
    logic [COUNT_W-1:0]   len_cnt_reg, len_cnt_next;
    logic [COUNT_W-1:0]   off_cnt_reg, off_cnt_next;
    logic [COUNT_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0]   len_acc_reg, len_acc_next;
    logic [VALUE_W-1:0]   off_acc_reg, off_acc_next;
    logic [VALUE_W-1:0]   running_reg, running_next;
    logic                 finished_reg, finished_next;
    logic                 res_valid_reg, res_valid_next;
    drld_run_t            res_reg, res_next;

    logic                 accept;
    drld_phase_t          phase_eff;
    logic [VALUE_W-1:0]   running_eff;
    logic                 finished_eff;
    logic [COUNT_W-1:0]   lc, oc, pos_inc;
    logic [VALUE_W-1:0]   shifted_byte, len_new, off_new, off_ext;
    logic [5:0]           sign_idx;
    logic                 sign_bit;

    assign in_ready  = !res_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_run   = res_reg;

    assign lc           = in_byte[3:0];
    assign oc           = in_byte[7:4];
    assign pos_inc      = pos_reg + COUNT_W'(1);
    assign shifted_byte = VALUE_W'(in_byte) << {pos_reg[2:0], 3'b000};
    assign len_new      = len_acc_reg | shifted_byte;
    assign off_new      = off_acc_reg | shifted_byte;

    // sign extension of the offset from off_cnt bytes
    assign sign_idx = 6'({off_cnt_reg, 3'b000} - 7'd1);
    assign sign_bit = off_new[sign_idx];
    always_comb begin
        off_ext = off_new;
        for (int k = 0; k < 8; k++) begin
            if (COUNT_W'(k) >= off_cnt_reg) begin
                off_ext[k*8 +: 8] = {8{sign_bit}};
            end
        end
    end

    always_comb begin
        phase_eff    = in_start ? PH_HEADER : phase_reg;
        running_eff  = in_start ? '0 : running_reg;
        finished_eff = in_start ? 1'b0 : finished_reg;

        phase_next    = phase_reg;
        len_cnt_next  = len_cnt_reg;
        off_cnt_next  = off_cnt_reg;
        pos_next      = pos_reg;
        len_acc_next  = len_acc_reg;
        off_acc_next  = off_acc_reg;
        running_next  = running_reg;
        finished_next = finished_reg;
        res_valid_next = res_valid_reg && !out_ready;
        res_next      = res_reg;

        if (accept) begin
            phase_next     = phase_eff;
            running_next   = running_eff;
            finished_next  = finished_eff;
            res_valid_next = 1'b0;
            res_next.status   = ST_TRUNCATED;
            res_next.clusters = '0;
            res_next.start    = running_eff;

            if (!finished_eff) begin
                case (phase_eff)
                    PH_HEADER: begin
                        if (lc == '0) begin
                            finished_next   = 1'b1;
                            res_valid_next  = 1'b1;
                            res_next.status = ST_END;
                        end else if (lc > MAX_FIELD_BYTES || oc > MAX_FIELD_BYTES) begin
                            finished_next   = 1'b1;
                            res_valid_next  = 1'b1;
                            res_next.status = ST_MALFORMED;
                        end else if (in_at_end) begin
                            finished_next   = 1'b1;
                            res_valid_next  = 1'b1;
                            res_next.status = ST_TRUNCATED;
                        end else begin
                            len_cnt_next = lc;
                            off_cnt_next = oc;
                            pos_next     = '0;
                            len_acc_next = '0;
                            off_acc_next = '0;
                            phase_next   = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        len_acc_next = len_new;
                        pos_next     = pos_inc;
                        if (pos_inc >= len_cnt_reg) begin
                            pos_next = '0;
                            if (off_cnt_reg == '0) begin
                                phase_next        = PH_HEADER;
                                finished_next     = in_at_end;
                                res_valid_next    = 1'b1;
                                res_next.status   = ST_RUN;
                                res_next.clusters = len_new;
                            end else if (in_at_end) begin
                                phase_next     = PH_HEADER;
                                finished_next  = 1'b1;
                                res_valid_next = 1'b1;
                            end else begin
                                phase_next = PH_OFFSET;
                            end
                        end else if (in_at_end) begin
                            phase_next     = PH_HEADER;
                            finished_next  = 1'b1;
                            res_valid_next = 1'b1;
                        end
                    end
                    PH_OFFSET: begin
                        off_acc_next = off_new;
                        pos_next     = pos_inc;
                        if (pos_inc >= off_cnt_reg) begin
                            pos_next          = '0;
                            phase_next        = PH_HEADER;
                            running_next      = running_reg + off_ext;
                            finished_next     = in_at_end;
                            res_valid_next    = 1'b1;
                            res_next.status   = ST_RUN;
                            res_next.clusters = len_acc_reg;
                            res_next.start    = running_reg + off_ext;
                        end else if (in_at_end) begin
                            phase_next     = PH_HEADER;
                            finished_next  = 1'b1;
                            res_valid_next = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            len_cnt_reg   <= '0;
            off_cnt_reg   <= '0;
            pos_reg       <= '0;
            len_acc_reg   <= '0;
            off_acc_reg   <= '0;
            running_reg   <= '0;
            finished_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            len_cnt_reg   <= len_cnt_next;
            off_cnt_reg   <= off_cnt_next;
            pos_reg       <= pos_next;
            len_acc_reg   <= len_acc_next;
            off_acc_reg   <= off_acc_next;
            running_reg   <= running_next;
            finished_reg  <= finished_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // a finished list ignores bytes that do not restart it
    a_finished_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && finished_reg && !in_start |=> $stable(running_reg) && finished_reg)
        else $error("running cluster moved after end of list");

    a_offset_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_OFFSET |-> off_cnt_reg != '0 && pos_reg < off_cnt_reg)
        else $error("offset phase with no offset bytes left");

    a_error_no_length: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && res_reg.status != ST_RUN |-> res_reg.clusters == '0)
        else $error("non-run result carries a length");

endmodule

FILE: rtl/core/drld_records.sv
// drld_records: two-stage record count pipeline (split multiply, then sum, shift, saturate)
// depends on drld_pkg

module drld_records (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  drld_pkg::drld_run_t          in_run,
    input  logic [drld_pkg::BPC_W-1:0]   bytes_per_cluster,
    output logic                         out_valid,
    input  logic                         out_ready,
    output drld_pkg::drld_run_t          out_run,
    output logic [drld_pkg::VALUE_W-1:0] out_records
);
    import drld_pkg::*;

    localparam int PART_W = HALF_W + BPC_W;
    localparam int PROD_W = VALUE_W + BPC_W;

    logic                 mul_valid_reg;
    drld_run_t            mul_run_reg;
    logic [PART_W-1:0]    p_lo_reg, p_hi_reg;

    logic                 out_valid_reg;
    drld_run_t            out_run_reg;
    logic [VALUE_W-1:0]   records_reg, records_next;

    logic                 ready_out, ready_mul;
    logic [PROD_W-1:0]    product;

    assign ready_out = !out_valid_reg || out_ready;
    assign ready_mul = !mul_valid_reg || ready_out;
    assign in_ready  = ready_mul;

    // full product, then divide by the record size with saturation
    assign product = PROD_W'(p_lo_reg) + (PROD_W'(p_hi_reg) << HALF_W);
    always_comb begin
        if (product[PROD_W-1 : VALUE_W+REC_SHIFT] != '0) begin
            records_next = '1;
        end else begin
            records_next = product[VALUE_W+REC_SHIFT-1 : REC_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ready_mul) begin
                mul_valid_reg <= in_valid;
            end
            if (ready_out) begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_mul) begin
            mul_run_reg <= in_run;
            p_lo_reg    <= PART_W'(in_run.clusters[HALF_W-1:0]) * PART_W'(bytes_per_cluster);
            p_hi_reg    <= PART_W'(in_run.clusters[VALUE_W-1:HALF_W])
                           * PART_W'(bytes_per_cluster);
        end
        if (ready_out) begin
            out_run_reg <= mul_run_reg;
            records_reg <= records_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_run     = out_run_reg;
    assign out_records = records_reg;

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_valid_reg && !ready_out |=> mul_valid_reg && $stable(mul_run_reg))
        else $error("multiply stage dropped a run");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(records_reg)
            && $stable(out_run_reg))
        else $error("stalled result changed");

    a_error_zero_records: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_run_reg.status != ST_RUN |-> records_reg == '0)
        else $error("non-run result carries a record count");

endmodule

FILE: rtl/core/data_run_list_decoder.sv
// data_run_list_decoder: top level, cluster size register, parser and record count pipeline
// depends on drld_pkg, drld_parser, drld_records
//
//  channel   direction  handshake                 payload
//  s_        in         s_tvalid / s_tready       tdata run byte, tuser list start, tlast attr end
//  m_        out        m_tvalid / m_tready       tdata length/start/records, tuser status
//  cfg_      in         cfg_valid / cfg_ready     cfg_data bytes per cluster
//
// a byte is taken every cycle unless a parser result is stalled; the parser registers each result
// the record count multiply is split over two registered stages after the parser
// stages advance independently; while m_ stalls, bytes flow only until a parser result is waiting
// reset clears the state machine, the running cluster and sets the cluster size to 4096

module data_run_list_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] run_byte
    input  logic                         s_tuser,   // [0] list_start
    input  logic                         s_tlast,   // attribute_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [191:0]                 m_tdata,   // [63:0] run_clusters, [127:64]
                                                    // start_cluster, [191:128] record_count
    output logic [drld_pkg::STATUS_W-1:0] m_tuser,  // [1:0] status
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [drld_pkg::BPC_W-1:0]   cfg_data
);
    import drld_pkg::*;

    logic [BPC_W-1:0]   bpc_reg;
    logic               run_valid, run_ready;
    drld_run_t          run_data;
    drld_run_t          out_run;
    logic [VALUE_W-1:0] out_records;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpc_reg <= BPC_RESET;
        end else if (cfg_valid) begin
            bpc_reg <= cfg_data;
        end
    end

    drld_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .in_at_end (s_tlast),
        .out_valid (run_valid),
        .out_ready (run_ready),
        .out_run   (run_data)
    );

    drld_records u_records (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (run_valid),
        .in_ready          (run_ready),
        .in_run            (run_data),
        .bytes_per_cluster (bpc_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_run           (out_run),
        .out_records       (out_records)
    );

    assign m_tdata = {out_records, out_run.start, out_run.clusters};
    assign m_tuser = out_run.status;

endmodule
